// ===== rtl/mapdt_pkg.sv =====
// Shared types and constants of the microphone-array peak direction tracker.
// No dependencies; the datapath, controller, top level and testbench import this package.
package mapdt_pkg;

	// direction codes
	localparam logic [3:0] DIR_SILENT  = 4'd13;
	localparam logic [3:0] DIR_WRAP    = 4'd11;
	localparam logic [3:0] DIR_GRP_MID = 4'd4;
	localparam logic [3:0] DIR_GRP_END = 4'd8;
	localparam logic [3:0] DIR_RIGHT   = 4'd2;
	localparam logic [3:0] DIR_STEP    = 4'd2;
	localparam logic [3:0] DIR_SPAN    = 4'd10;
	localparam logic [8:0] DEG_PER_DIR = 9'd30;

	// configuration register indexes
	localparam logic [1:0] REG_FRAME_WORDS    = 2'd0;
	localparam logic [1:0] REG_PEAK_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_HISTORY_LENGTH = 2'd2;

	// configuration reset values
	localparam logic [15:0] FRAME_WORDS_RST    = 16'd1500;
	localparam logic [22:0] PEAK_THRESHOLD_RST = 23'd15000;
	localparam logic [4:0]  HISTORY_LENGTH_RST = 5'd4;

	// x/3 == (x * RECIP3) >> 18, exact for any x below 2**17
	localparam logic [16:0] RECIP3     = 17'h15556;
	localparam logic [14:0] THIRD1_RST = 15'd500;
	localparam logic [15:0] THIRD2_RST = 16'd1000;

	typedef struct packed {
		logic load;      // take one sample
		logic classify;  // classify the finished frame, shift it into history
		logic scan;      // one history scan step
		logic decide;    // settle the stable direction, load the result register
	} mapdt_cmd_t;

	typedef struct packed {
		logic frame_end;  // the sample on offer closes the frame
		logic scan_last;  // the current scan step is the last one
		logic out_full;   // result register cannot take a new result this cycle
	} mapdt_sts_t;

endpackage

// ===== rtl/mapdt_if.sv =====
// Request channels of the tracker: sample input, result output, register writes.
// Plain valid/ready interfaces; no package dependency.
interface mapdt_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] high_word;
	logic        [15:0] low_word;

	modport source (output valid, output high_word, output low_word, input ready);
	modport sink   (input valid, input high_word, input low_word, output ready);
endinterface

interface mapdt_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] coarse_direction;
	logic [3:0] stable_direction;
	logic [8:0] held_angle;

	modport source (output valid, output coarse_direction, output stable_direction,
		output held_angle, input ready);
	modport sink   (input valid, input coarse_direction, input stable_direction,
		input held_angle, output ready);
endinterface

interface mapdt_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [22:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mapdt_datapath.sv =====
// Datapath: config registers, peak tracking, frame classification, history
// rotator with stabilizing scan, confirmation counter and result register.
// Depends on mapdt_pkg and mapdt_if.
module mapdt_datapath #(
	parameter int MAX_HISTORY    = 16,
	parameter int STABLE_REPEATS = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mapdt_in_if.sink              sample,
	mapdt_out_if.source           result,
	mapdt_cfg_if.sink             cfg,
	input  mapdt_pkg::mapdt_cmd_t cmd,
	output mapdt_pkg::mapdt_sts_t sts
);
	import mapdt_pkg::*;

	localparam int LW = $clog2(MAX_HISTORY + 1);
	localparam int CW = (LW > 5) ? LW : 5;

	// configuration
	logic [15:0] frame_words_q;
	logic [22:0] peak_threshold_q;
	logic [4:0]  history_length_q;
	logic [14:0] third1_q;
	logic [15:0] third2_q;
	logic [32:0] third_prod;

	// frame state
	logic signed [23:0] peak_q;
	logic        [15:0] peak_idx_q;
	logic        [15:0] word_pos_q;
	logic        [22:0] cls_peak_q;
	logic        [15:0] cls_idx_q;
	logic signed [23:0] samp;
	logic signed [23:0] new_peak;
	logic        [15:0] new_idx;
	logic        [16:0] next_pos;

	// history and scan
	logic [3:0]    hist_q [MAX_HISTORY];
	logic [3:0]    hist_nx [MAX_HISTORY];
	logic [3:0]    ins_val;
	logic          rot_en;
	logic [CW-1:0] hl_w;
	logic [LW-1:0] eff_len;
	logic [LW-1:0] len_m1;
	logic [LW-1:0] scan_k_q;
	logic [3:0]    first_q;
	logic [3:0]    second_q;
	logic          have2_q;
	logic          many_q;

	// decision
	logic [3:0] coarse;
	logic [3:0] coarse_q;
	logic [3:0] last_stable_q;
	logic [7:0] rep_cnt_q;
	logic [8:0] angle_q;
	logic [3:0] lo;
	logic [3:0] hi;
	logic [3:0] diff;
	logic [3:0] stable;
	logic [7:0] rep_inc;
	logic       confirm;
	logic [8:0] angle_nx;

	// result register
	logic       out_valid_q;
	logic [3:0] out_coarse_q;
	logic [3:0] out_stable_q;
	logic [8:0] out_angle_q;

	// ---- configuration writes ----
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_words_q    <= FRAME_WORDS_RST;
			peak_threshold_q <= PEAK_THRESHOLD_RST;
			history_length_q <= HISTORY_LENGTH_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FRAME_WORDS:    frame_words_q    <= cfg.data[15:0];
				REG_PEAK_THRESHOLD: peak_threshold_q <= cfg.data;
				REG_HISTORY_LENGTH: history_length_q <= cfg.data[4:0];
				default: ;
			endcase
		end
	end

	// frame thirds by reciprocal multiply, registered from frame_words
	assign third_prod = 33'(frame_words_q) * 33'(RECIP3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			third1_q <= THIRD1_RST;
			third2_q <= THIRD2_RST;
		end else begin
			third1_q <= third_prod[32:18];
			third2_q <= third_prod[32:17];
		end
	end

	// ---- peak tracking ----
	assign samp     = signed'({sample.high_word, sample.low_word[15:8]});
	assign new_peak = (samp > peak_q) ? samp : peak_q;
	assign new_idx  = (samp > peak_q) ? word_pos_q : peak_idx_q;
	assign next_pos = {1'b0, word_pos_q} + 17'd2;

	assign sts.frame_end = (next_pos >= {1'b0, frame_words_q});
	assign sample.ready  = cmd.load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q     <= '0;
			peak_idx_q <= '0;
			word_pos_q <= '0;
		end else if (cmd.load && sample.valid) begin
			if (sts.frame_end) begin
				peak_q     <= '0;
				peak_idx_q <= '0;
				word_pos_q <= '0;
			end else begin
				peak_q     <= new_peak;
				peak_idx_q <= new_idx;
				word_pos_q <= next_pos[15:0];
			end
		end
	end

	// peak never goes negative, so its low 23 bits carry it
	always_ff @(posedge clk) begin
		if (cmd.load && sample.valid && sts.frame_end) begin
			cls_peak_q <= new_peak[22:0];
			cls_idx_q  <= new_idx;
		end
	end

	// ---- classification ----
	always_comb begin
		if (cls_peak_q < peak_threshold_q) begin
			coarse = DIR_SILENT;
		end else begin
			if (cls_idx_q < {1'b0, third1_q})
				coarse = '0;
			else if (cls_idx_q < third2_q)
				coarse = DIR_GRP_MID;
			else
				coarse = DIR_GRP_END;
			if (cls_idx_q[1:0] != 2'd0)
				coarse = coarse + DIR_RIGHT;
		end
	end

	// ---- history: rotate the first len entries, inserting at the tail ----
	assign hl_w    = CW'(history_length_q);
	assign eff_len = (hl_w == '0) ? LW'(1) :
		(hl_w > CW'(MAX_HISTORY)) ? LW'(MAX_HISTORY) : LW'(hl_w);
	assign len_m1  = eff_len - LW'(1);
	assign rot_en  = cmd.classify || cmd.scan;
	assign ins_val = cmd.classify ? coarse : hist_q[0];

	for (genvar j = 0; j < MAX_HISTORY; j++) begin : g_hist
		if (j < MAX_HISTORY - 1) begin : g_mid
			assign hist_nx[j] = (LW'(j) < len_m1) ? hist_q[j+1] :
				(LW'(j) == len_m1) ? ins_val : hist_q[j];
		end else begin : g_end
			assign hist_nx[j] = (LW'(j) == len_m1) ? ins_val : hist_q[j];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				hist_q[j] <= DIR_SILENT;
			else if (rot_en)
				hist_q[j] <= hist_nx[j];
		end
	end

	// ---- scan: head entry each step, counting distinct values ----
	assign sts.scan_last = (scan_k_q == len_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_k_q <= '0;
			have2_q  <= 1'b0;
			many_q   <= 1'b0;
		end else if (cmd.classify) begin
			scan_k_q <= '0;
		end else if (cmd.scan) begin
			scan_k_q <= scan_k_q + LW'(1);
			if (scan_k_q == '0) begin
				have2_q <= 1'b0;
				many_q  <= 1'b0;
			end else if (hist_q[0] != first_q && !(have2_q && hist_q[0] == second_q)) begin
				if (have2_q)
					many_q <= 1'b1;
				else
					have2_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.classify)
			coarse_q <= coarse;
		if (cmd.scan) begin
			if (scan_k_q == '0)
				first_q <= hist_q[0];
			else if (!have2_q && hist_q[0] != first_q)
				second_q <= hist_q[0];
		end
	end

	// ---- stable direction and confirmation ----
	assign lo   = (first_q < second_q) ? first_q : second_q;
	assign hi   = (first_q < second_q) ? second_q : first_q;
	assign diff = hi - lo;

	always_comb begin
		if (many_q)
			stable = last_stable_q;
		else if (!have2_q)
			stable = first_q;
		else if (diff == DIR_STEP)
			stable = lo + 4'd1;
		else if (diff == DIR_SPAN)
			stable = DIR_WRAP;
		else
			stable = last_stable_q;
	end

	assign rep_inc  = (stable == last_stable_q) ? rep_cnt_q + 8'd1 : rep_cnt_q;
	assign confirm  = (stable != DIR_SILENT) && (rep_inc >= 8'(STABLE_REPEATS));
	assign angle_nx = confirm ? 9'(9'(stable) * DEG_PER_DIR) : angle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_stable_q <= DIR_SILENT;
			rep_cnt_q     <= '0;
			angle_q       <= '0;
		end else if (cmd.decide) begin
			last_stable_q <= stable;
			rep_cnt_q     <= confirm ? 8'd0 : rep_inc;
			angle_q       <= angle_nx;
		end
	end

	// ---- result register ----
	assign sts.out_full = out_valid_q && !result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.decide)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			out_coarse_q <= coarse_q;
			out_stable_q <= stable;
			out_angle_q  <= angle_nx;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.coarse_direction = out_coarse_q;
	assign result.stable_direction = out_stable_q;
	assign result.held_angle       = out_angle_q;

	// ---- checks ----
	a_pos_even: assert property (@(posedge clk) disable iff (!arst_n)
		word_pos_q[0] == 1'b0)
		else $error("word position went odd");

	a_coarse_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_coarse_q == DIR_SILENT ||
			(out_coarse_q[0] == 1'b0 && out_coarse_q <= DIR_SPAN)))
		else $error("illegal coarse direction in result");

	a_angle_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |=> (out_angle_q == angle_q && angle_q <= 9'd330))
		else $error("held angle out of step with confirmation state");
endmodule

// ===== rtl/mapdt_ctrl.sv =====
// Controller: sequences sample intake and the end-of-frame work
// (classify, history scan, decide). Depends on mapdt_pkg.
module mapdt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  mapdt_pkg::mapdt_sts_t sts,
	output mapdt_pkg::mapdt_cmd_t cmd
);
	import mapdt_pkg::*;

	localparam logic [1:0] S_RUN    = 2'd0;
	localparam logic [1:0] S_CLASS  = 2'd1;
	localparam logic [1:0] S_SCAN   = 2'd2;
	localparam logic [1:0] S_DECIDE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nx;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_RUN: begin
				cmd.load = 1'b1;
				if (in_valid && sts.frame_end)
					state_nx = S_CLASS;
			end
			S_CLASS: begin
				cmd.classify = 1'b1;
				state_nx     = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last)
					state_nx = S_DECIDE;
			end
			S_DECIDE: begin
				// wait for room in the result register
				if (!sts.out_full) begin
					cmd.decide = 1'b1;
					state_nx   = S_RUN;
				end
			end
			default: state_nx = S_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_RUN;
		else
			state_q <= state_nx;
	end

	a_class_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLASS) |-> $past(cmd.load && in_valid && sts.frame_end))
		else $error("classify entered without a frame-ending sample");
endmodule

// ===== rtl/mic_array_peak_direction_tracker.sv =====
// Top level of the microphone-array peak direction tracker.
// Depends on mapdt_pkg, mapdt_if, mapdt_ctrl and mapdt_datapath.
//
// port     dir  carries                                          accepted when
// -------  ---  -----------------------------------------------  -------------------
// sample   in   high_word (s16), low_word (u16): one sample      valid && ready
// result   out  coarse_direction, stable_direction, held_angle    valid && ready
// cfg      in   index (0 frame_words, 1 peak_threshold,          valid && ready
//               2 history_length), data                          (ready always high)
//
// Cycles: a sample request is taken every cycle inside a frame. The sample that
// closes a frame is followed by a pause without ready (a classify step, len
// scan steps over the history through its head tap, a decide step), where len is
// the effective history length that the history rotator sets.
// Reset: asynchronous, active low; history comes up all silent, registers at defaults.
// Stalls: the result register holds one result; while it is still full the next
// frame's decide step waits, and samples are taken again once it has gone through.
module mic_array_peak_direction_tracker #(
	parameter int MAX_HISTORY    = 16,
	parameter int STABLE_REPEATS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	mapdt_in_if.sink    sample,
	mapdt_out_if.source result,
	mapdt_cfg_if.sink   cfg
);
	import mapdt_pkg::*;

	// command and status between sequencer and datapath
	mapdt_cmd_t cmd;
	mapdt_sts_t sts;

	// Sequencer: intake state gives ready, then walks the frame-end steps.
	mapdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: peak search, thirds of the frame, history and stabilizer,
	// repeat counter for the held angle, result register.
	mapdt_datapath #(
		.MAX_HISTORY    (MAX_HISTORY),
		.STABLE_REPEATS (STABLE_REPEATS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.result (result),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for mic_array_peak_direction_tracker.
// Depends on mapdt_pkg, the request interfaces in mapdt_if and the tracker RTL.
// Frames of samples go in, every frame result is predicted and compared per field.
module testbench;
	import mapdt_pkg::*;

	localparam int HISTORY_DEPTH  = 16;
	localparam int STABLE_REPEATS = 2;
	localparam int IDLE_LIMIT     = 4000;              // cycles without any request
	localparam int SETTLE_CYCLES  = HISTORY_DEPTH + 8; // longest frame-end scan plus margin
	localparam int RANDOM_SAMPLES = 340;

	typedef struct packed {
		logic [3:0] coarse;
		logic [3:0] stable;
		logic [8:0] angle;
	} dir_result_t;

	logic clk;
	logic arst_n;

	mapdt_in_if  sample_ch ();
	mapdt_out_if result_ch ();
	mapdt_cfg_if cfg_ch ();

	mic_array_peak_direction_tracker #(
		.MAX_HISTORY   (HISTORY_DEPTH),
		.STABLE_REPEATS(STABLE_REPEATS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch),
		.cfg   (cfg_ch)
	);

	// ---------------------------------------------------------------------
	// Predicted tracker state and register copies
	// ---------------------------------------------------------------------
	logic [15:0]        frame_words_q;
	logic [22:0]        threshold_q;
	logic [4:0]         hist_len_q;
	logic signed [23:0] peak_level;
	logic [15:0]        peak_pos;
	logic [15:0]        word_pos;
	logic [3:0]         history_dirs [HISTORY_DEPTH];
	logic [3:0]         last_stable;
	logic [7:0]         repeat_count;
	logic [8:0]         held_angle_q;

	dir_result_t pending_dirs [$];  // frame results still owed by the DUT
	int          mismatch_count;
	int          samples_sent;
	int          idle_cycles;
	bit          no_idle;           // when set, neither side inserts gaps

	function automatic void reset_tracker();
		frame_words_q = FRAME_WORDS_RST;
		threshold_q   = PEAK_THRESHOLD_RST;
		hist_len_q    = HISTORY_LENGTH_RST;
		peak_level    = '0;
		peak_pos      = '0;
		word_pos      = '0;
		foreach (history_dirs[k])
			history_dirs[k] = DIR_SILENT;
		last_stable   = DIR_SILENT;
		repeat_count  = '0;
		held_angle_q  = '0;
	endfunction

	// 0 behaves as 1, anything past the history depth is clamped
	function automatic int history_span();
		if (hist_len_q == 0)
			return 1;
		if (int'(hist_len_q) > HISTORY_DEPTH)
			return HISTORY_DEPTH;
		return int'(hist_len_q);
	endfunction

	function automatic logic [3:0] classify_direction();
		int         third1;
		int         third2;
		logic [3:0] dir;
		if (int'(peak_level) < int'({1'b0, threshold_q}))
			return DIR_SILENT;
		third1 = int'(frame_words_q) / 3;
		third2 = (int'(frame_words_q) * 2) / 3;
		// an index past the frame (after a shrink) lands in the last group
		if (int'(peak_pos) < third1)
			dir = 4'd0;
		else if (int'(peak_pos) < third2)
			dir = DIR_GRP_MID;
		else
			dir = DIR_GRP_END;
		if (peak_pos[1:0] != 2'b00)
			dir = dir + DIR_RIGHT;
		return dir;
	endfunction

	// one value passes, a pair 2 apart gives the midpoint, 0/10 gives 11,
	// anything else keeps the previous stable direction
	function automatic logic [3:0] settle_direction(int len);
		logic [3:0] first;
		logic [3:0] second;
		logic [3:0] v;
		logic [3:0] lo;
		logic [3:0] hi;
		bit         have_second;
		first       = history_dirs[0];
		second      = first;
		have_second = 1'b0;
		for (int k = 1; k < len; k++) begin
			v = history_dirs[k];
			if (v == first || (have_second && v == second))
				continue;
			if (have_second)
				return last_stable;
			second      = v;
			have_second = 1'b1;
		end
		if (!have_second)
			return first;
		lo = (first < second) ? first : second;
		hi = (first < second) ? second : first;
		if (hi - lo == DIR_STEP)
			return lo + 4'd1;
		if (hi - lo == DIR_SPAN)
			return DIR_WRAP;
		return last_stable;
	endfunction

	function automatic void track_sample(logic signed [15:0] hw, logic [15:0] lw);
		logic signed [23:0] level;
		int                 next_pos;
		int                 len;
		logic [3:0]         coarse;
		logic [3:0]         stable;
		level = {hw, lw[15:8]};
		if (level > peak_level) begin
			peak_level = level;
			peak_pos   = word_pos;
		end
		next_pos = int'(word_pos) + 2;
		if (next_pos < int'(frame_words_q)) begin
			word_pos = 16'(next_pos);
			return;
		end
		// frame end
		coarse = classify_direction();
		len    = history_span();
		for (int k = 0; k + 1 < len; k++)
			history_dirs[k] = history_dirs[k + 1];
		history_dirs[len - 1] = coarse;
		stable = settle_direction(len);
		if (stable == last_stable)
			repeat_count = repeat_count + 8'd1;
		if (stable != DIR_SILENT && int'(repeat_count) >= STABLE_REPEATS) begin
			held_angle_q = 9'(stable) * DEG_PER_DIR;
			repeat_count = '0;
		end
		last_stable = stable;
		peak_level  = '0;
		peak_pos    = '0;
		word_pos    = '0;
		pending_dirs.push_back('{coarse, stable, held_angle_q});
	endfunction

	// ---------------------------------------------------------------------
	// Clock, monitors, checker, watchdog
	// ---------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// register writes and sample requests feed the prediction at the edge they are taken
	always @(posedge clk) begin
		if (arst_n && cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.index)
				REG_FRAME_WORDS:    frame_words_q = cfg_ch.data[15:0];
				REG_PEAK_THRESHOLD: threshold_q   = cfg_ch.data;
				REG_HISTORY_LENGTH: hist_len_q    = cfg_ch.data[4:0];
				default: ;
			endcase
		end
		if (arst_n && sample_ch.valid && sample_ch.ready)
			track_sample(sample_ch.high_word, sample_ch.low_word);
	end

	function automatic void check_field(string field, int want, int got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endfunction

	always @(posedge clk) begin
		dir_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_dirs.size() == 0) begin
				mismatch_count++;
				$display("%0t: result with none expected, expected nothing, actual %0d/%0d/%0d",
					$time, result_ch.coarse_direction, result_ch.stable_direction,
					result_ch.held_angle);
			end else begin
				want = pending_dirs.pop_front();
				check_field("coarse_direction", want.coarse, result_ch.coarse_direction);
				check_field("stable_direction", want.stable, result_ch.stable_direction);
				check_field("held_angle", want.angle, result_ch.held_angle);
			end
		end
	end

	// any request on any channel counts as progress
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no request for %0d cycles", $time, IDLE_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// mostly no gap, sometimes a short one, rarely a long one
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// result side back-pressure
	initial begin
		int g;
		forever begin
			result_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			g = pick_gap();
			if (g > 0) begin
				result_ch.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Request drivers
	// ---------------------------------------------------------------------
	// valid stays high on return so back-to-back requests need no extra edge
	task automatic send_sample(input logic signed [15:0] hw, input logic [15:0] lw);
		int g;
		g = pick_gap();
		if (g > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		sample_ch.valid     <= 1'b1;
		sample_ch.high_word <= hw;
		sample_ch.low_word  <= lw;
		do @(posedge clk); while (!sample_ch.ready);
		samples_sent++;
	endtask

	// stop sending, let every owed result arrive, then give the scan time to finish
	task automatic drain();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_dirs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [22:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic set_config(input logic [22:0] fw, input logic [22:0] thr,
			input logic [22:0] hl);
		drain();
		write_reg(REG_FRAME_WORDS, fw);
		write_reg(REG_PEAK_THRESHOLD, thr);
		write_reg(REG_HISTORY_LENGTH, hl);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic int frame_samples(int fw);
		return (fw <= 2) ? 1 : (fw + 1) / 2;
	endfunction

	// strictly negative, so it never becomes the peak
	function automatic logic signed [15:0] quiet_word();
		return 16'(32'd65536 - $urandom_range(1, 32768));
	endfunction

	// n samples, the one at loud_at carries loud_hw; loud_at < 0 gives a silent frame
	task automatic send_frame(input int n, input int loud_at,
			input logic signed [15:0] loud_hw);
		for (int i = 0; i < n; i++)
			send_sample((i == loud_at) ? loud_hw : quiet_word(), 16'($urandom));
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------
	// reset registers: threshold 15000 and a history of 4 come from reset; the
	// 1500-word default frame is cut short by rewriting frame_words alone
	task automatic test_reset_defaults();
		// exactly at the threshold, word 6
		for (int i = 0; i < 6; i++)
			send_sample((i == 3) ? 16'sd58 : quiet_word(),
				(i == 3) ? {8'h98, 8'($urandom)} : 16'($urandom));
		drain();
		write_reg(REG_FRAME_WORDS, 23'd16);
		cfg_ch.valid <= 1'b0;
		repeat (2) send_sample(quiet_word(), 16'($urandom));
		// just under the threshold: silent
		for (int i = 0; i < 8; i++)
			send_sample((i == 3) ? 16'sd58 : quiet_word(),
				(i == 3) ? {8'h97, 8'($urandom)} : 16'($urandom));
	endtask

	// field extremes, threshold boundaries, equal peaks, all-negative frames
	task automatic test_field_extremes();
		set_config(23'd4, 23'h7FFFFF, 23'd1);
		send_sample(16'sh7FFF, 16'hFFFF);  // largest sample equals max threshold
		send_sample(16'sd0, 16'h0000);
		send_sample(16'sd0, 16'h0000);
		send_sample(16'sh7FFF, 16'hFEFF);  // one below threshold
		send_sample(-16'sd32768, 16'h0000);
		send_sample(-16'sd1, 16'hFFFF);
		set_config(23'd4, 23'd0, 23'd1);
		send_sample(-16'sd32768, 16'h0000); // all negative: peak 0 at index 0
		send_sample(-16'sd1, 16'hFFFF);
		send_sample(16'sd0, 16'h00FF);     // low byte of low_word is dropped
		send_sample(16'sd0, 16'h0100);     // right channel, last third
		send_sample(16'sd5, 16'h0000);
		send_sample(16'sd5, 16'h0000);     // equal sample keeps the first index
	endtask

	// below three words each sample is a whole frame
	task automatic test_tiny_frames();
		for (int fw = 0; fw < 4; fw++) begin
			set_config(23'(fw), 23'd0, 23'd1);
			repeat (3) send_sample(16'($urandom), 16'($urandom));
		end
	endtask

	// 12-word frames: sample slot i maps to direction 2*i
	task automatic test_history_settle();
		int slots [] = '{0, 0, 0, 0, 1, 1, 5, 0, 5, 0, -1, -1, -1, -1, 3, 4, 4, 4, 4};
		set_config(23'd12, 23'd256, 23'd4);
		foreach (slots[i])
			send_frame(6, slots[i], 16'($urandom_range(1, 32767)));
	endtask

	// zero and over-range lengths, and stale entries past a shortened history
	task automatic test_history_length();
		set_config(23'd12, 23'd256, 23'd0);
		send_frame(6, 2, 16'sd300);
		send_frame(6, 3, 16'sd300);
		set_config(23'd12, 23'd256, 23'd31);
		repeat (3) send_frame(6, 0, 16'sd300);
		set_config(23'd12, 23'd256, 23'd2);
		repeat (3) send_frame(6, 5, 16'sd300);
		set_config(23'd12, 23'd256, 23'd16);
		send_frame(6, 5, 16'sd300);
		set_config(23'd12, 23'd256, 23'd17);
		send_frame(6, 4, 16'sd300);
	endtask

	// frame shrinks mid-frame: the peak index lies past the new frame size
	task automatic test_midframe_resize();
		set_config(23'd40, 23'd256, 23'd1);
		send_frame(10, 8, 16'sd1000);
		set_config(23'd8, 23'd256, 23'd1);
		send_sample(quiet_word(), 16'($urandom));
		set_config(23'd40, 23'd256, 23'd1);
		send_frame(10, 9, 16'sd1000);
		set_config(23'd8, 23'd256, 23'd1);
		send_sample(quiet_word(), 16'($urandom));
	endtask

	// long silent run wraps the 8-bit repeat counter before a direction shows up
	task automatic test_repeat_wrap();
		set_config(23'd2, 23'h7FFFFF, 23'd1);
		repeat (258) send_sample(quiet_word(), 16'($urandom));
		set_config(23'd2, 23'd0, 23'd1);
		repeat (4) send_sample(16'($urandom_range(0, 32767)), 16'($urandom));
	endtask

	// largest frame sizes: the word count runs on without closing the frame,
	// then a shrink closes it; samples go back to back
	task automatic test_large_frames();
		no_idle = 1'b1;
		set_config(23'd65535, 23'd256, 23'd16);
		send_frame(6, 4, 16'sd2000);
		set_config(23'd32768, 23'd256, 23'd16);
		send_frame(6, -1, 16'sd0);
		set_config(23'd4, 23'd256, 23'd16);
		send_sample(quiet_word(), 16'($urandom));
		no_idle = 1'b0;
	endtask

	// phases of random settings; frames mostly keep one source position so the
	// history settles, with neighbors, 0/10 swaps, silent frames and noise mixed in
	task automatic test_random();
		int          start_count;
		int          n;
		int          base;
		int          slot;
		int          r;
		int          frames;
		logic [15:0] fw;
		logic [22:0] thr;
		start_count = samples_sent;
		while (samples_sent - start_count < RANDOM_SAMPLES) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				fw = 16'($urandom_range(0, 3));
			else if (r < 85)
				fw = 16'($urandom_range(4, 24));
			else
				fw = 16'($urandom_range(25, 200));
			r = $urandom_range(0, 99);
			if (r < 20)
				thr = 23'd0;
			else if (r < 70)
				thr = 23'($urandom_range(0, 65535));
			else if (r < 90)
				thr = 23'($urandom);
			else
				thr = 23'h7FFFFF;
			// upper data bits beyond each register are don't-care
			set_config({7'($urandom), fw}, thr,
				{18'($urandom), 5'($urandom_range(0, 31))});
			no_idle = ($urandom_range(0, 4) == 0);
			n       = frame_samples(int'(fw));
			base    = $urandom_range(0, n - 1);
			frames  = $urandom_range(4, 16);
			for (int f = 0; f < frames; f++) begin
				if (samples_sent - start_count >= RANDOM_SAMPLES)
					break;
				r = $urandom_range(0, 99);
				if (r < 55)
					slot = base;
				else if (r < 70)
					slot = (base + 1 < n) ? base + 1 : ((base > 0) ? base - 1 : 0);
				else if (r < 78)
					slot = $urandom_range(0, 1) ? 0 : ((n - 1) % 2 ? n - 1 : n - 2);
				else if (r < 86)
					slot = -1;
				else if (r < 94)
					slot = $urandom_range(0, n - 1);
				else
					slot = -2;
				if (slot < -1) begin
					for (int i = 0; i < n; i++)
						send_sample(16'($urandom), 16'($urandom));
				end else begin
					send_frame(n, (slot < 0 && slot != -1) ? 0 : slot,
						16'($urandom_range(0, 32767)));
				end
			end
			// now and then leave a frame unfinished across the settings change
			if ($urandom_range(0, 9) == 0)
				send_frame($urandom_range(0, n - 1), -1, 16'sd0);
		end
		no_idle = 1'b0;
	endtask

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin
		mismatch_count = 0;
		samples_sent   = 0;
		idle_cycles    = 0;
		no_idle        = 1'b0;
		reset_tracker();
		arst_n              <= 1'b0;
		sample_ch.valid     <= 1'b0;
		sample_ch.high_word <= '0;
		sample_ch.low_word  <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= REG_FRAME_WORDS;
		cfg_ch.data         <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_field_extremes();
		test_tiny_frames();
		test_history_settle();
		test_history_length();
		test_midframe_resize();
		test_repeat_wrap();
		test_large_frames();
		test_random();

		drain();
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/mapdt_pkg.sv
rtl/mapdt_if.sv
rtl/mapdt_datapath.sv
rtl/mapdt_ctrl.sv
rtl/mic_array_peak_direction_tracker.sv
tb/testbench.sv
